// ----- rtl/itda_pkg.sv -----
// Package for the integer to decimal ASCII converter.
// Holds mode codes, width selects, command/status structs and the BCD shift step.
// No dependencies.
package itda_pkg;

  localparam int MODE_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int DIGITS   = 20;
  localparam int IDX_W    = 5;
  localparam int STEP_W   = 4;
  localparam int WORK_W   = 64;
  localparam int BITS_PER_STEP = 4;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_S16 = 3'd0;
  localparam mode_t MODE_U16 = 3'd1;
  localparam mode_t MODE_S32 = 3'd2;
  localparam mode_t MODE_U32 = 3'd3;
  localparam mode_t MODE_S64 = 3'd4;
  localparam mode_t MODE_U64 = 3'd5;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    WID_16,
    WID_32,
    WID_64
  } width_t;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic count;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic steps_last;
    logic negative;
    logic idx_zero;
    logic out_free;
  } dp_status_t;

  // Four double-dabble steps: correct each digit, then shift one bit in.
  function automatic bcd_t dabble_step(input bcd_t bcd_in, input logic [BITS_PER_STEP-1:0] nib);
    bcd_t b;
    logic [DIGITS*4-1:0] flat;
    b = bcd_in;
    for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d] >= 4'd5) begin
          b[d] = b[d] + 4'd3;
        end
      end
      flat = b;
      flat = {flat[DIGITS*4-2:0], nib[s]};
      b    = flat;
    end
    return b;
  endfunction

endpackage

// ----- rtl/itda_if.sv -----
// Handshake channels of the integer to decimal ASCII converter.
// Depends on itda_pkg for field widths.
interface itda_in_if import itda_pkg::*; #(parameter int VALUE_BITS = 64);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value_bits;
  logic [MODE_W-1:0]     mode;

  modport source (output valid, value_bits, mode, input ready);
  modport sink   (input valid, value_bits, mode, output ready);
endinterface

interface itda_out_if import itda_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

// ----- rtl/itda_ctrl.sv -----
// Sequencer of the converter: load, BCD conversion, digit count, character emission.
// Depends on itda_pkg; drives the datapath by command struct only.
module itda_ctrl import itda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (status.steps_last) state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        state_nxt = status.negative ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (status.out_free) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status.out_free && status.idx_zero) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = status.out_free;
      end
      ST_DIGIT: begin
        cmd.emit_digit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/itda_dp.sv -----
// Datapath of the converter: magnitude, BCD digit store, digit index, output register.
// Depends on itda_pkg; steered by itda_ctrl through command and status structs.
module itda_dp import itda_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value_bits,
  input  logic [MODE_W-1:0]     in_mode,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char_code,
  output logic                  out_last
);

  logic [WORK_W-1:0] work_value_r;
  bcd_t              digit_store_r;
  logic [IDX_W-1:0]  digit_count_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic [WORK_W-1:0] raw, x, mask, mag;
  logic              is_signed, sign_bit;
  width_t            wsel;
  logic [STEP_W-1:0] steps_init;
  logic [IDX_W-1:0]  lead;

  always_comb begin
    unique case (in_mode)
      MODE_S16: begin wsel = WID_16; is_signed = 1'b1; end
      MODE_U16: begin wsel = WID_16; is_signed = 1'b0; end
      MODE_S32: begin wsel = WID_32; is_signed = 1'b1; end
      MODE_U32: begin wsel = WID_32; is_signed = 1'b0; end
      MODE_S64: begin wsel = WID_64; is_signed = 1'b1; end
      default:  begin wsel = WID_64; is_signed = 1'b0; end
    endcase
  end

  assign raw = WORK_W'(in_value_bits);

  always_comb begin
    unique case (wsel)
      WID_16: begin
        mask       = 64'h0000_0000_0000_FFFF;
        steps_init = STEP_W'(16 / BITS_PER_STEP - 1);
      end
      WID_32: begin
        mask       = 64'h0000_0000_FFFF_FFFF;
        steps_init = STEP_W'(32 / BITS_PER_STEP - 1);
      end
      default: begin
        mask       = 64'hFFFF_FFFF_FFFF_FFFF;
        steps_init = STEP_W'(64 / BITS_PER_STEP - 1);
      end
    endcase
  end

  assign x = raw & mask;

  always_comb begin
    unique case (wsel)
      WID_16:  sign_bit = x[15];
      WID_32:  sign_bit = x[31];
      default: sign_bit = x[63];
    endcase
  end

  // Two's complement within the width gives the exact magnitude, minimum included.
  assign mag = (is_signed && sign_bit) ? ((~x + 64'd1) & mask) : x;

  // Highest non-zero digit; zero leaves the units digit alone.
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (digit_store_r[i] != 4'd0) lead = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (wsel)
        WID_16:  work_value_r <= mag << 48;
        WID_32:  work_value_r <= mag << 32;
        default: work_value_r <= mag;
      endcase
      digit_store_r <= '0;
      step_r        <= steps_init;
      neg_r         <= is_signed && sign_bit;
    end else if (cmd.shift) begin
      digit_store_r <= dabble_step(digit_store_r,
                                   work_value_r[WORK_W-1 -: BITS_PER_STEP]);
      work_value_r  <= work_value_r << BITS_PER_STEP;
      step_r        <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
    end else if (cmd.count) begin
      digit_count_r <= lead;
    end else if (cmd.emit_digit && digit_count_r != '0) begin
      digit_count_r <= digit_count_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + CHAR_W'(digit_store_r[digit_count_r]);
      out_last_r <= (digit_count_r == '0);
    end
  end

  assign status.steps_last = (step_r == '0);
  assign status.negative   = neg_r;
  assign status.idx_zero   = (digit_count_r == '0);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/integer_to_decimal_ascii_top.sv -----
// Top level of the integer to decimal ASCII converter.
// Depends on itda_pkg, itda_if, itda_ctrl and itda_dp.
//
//   channel  dir  beat fields              accepted when
//   in_ch    in   value_bits, mode         valid && ready
//   out_ch   out  char_code, last          valid && ready
//
// After accept, a number passes through the four-bit double-dabble step over the
// W mode bits (W is 16, 32 or 64), then the digit count, then its N characters
// (1 to 20), one char a cycle while the out channel does not stall.
// Reset is synchronous, active low; the digit store needs no clearing.
// A stalled out beat holds and the sequencer waits; the next number is taken
// while the final character still sits in the output register.
module integer_to_decimal_ascii_top import itda_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input logic         clk,
  input logic         rst_n,
  itda_in_if.sink     in_ch,
  itda_out_if.source  out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  itda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  itda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value_bits (in_ch.value_bits),
    .in_mode       (in_ch.mode),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last)
  );

endmodule

// ----- rtl/itda_checker.sv -----
// Port-level checks of the integer to decimal ASCII converter, bound to the top.
// Depends on itda_pkg for character codes.
module itda_checker import itda_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char_code,
  input logic              out_last
);

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("out beat changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS) ||
                  (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_NINE))
    else $error("character outside sign and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == CHAR_MINUS) |-> !out_last)
    else $error("sign flagged as final character");

  // More characters pending: no new number may be taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken mid-number");

endmodule

bind integer_to_decimal_ascii_top itda_checker u_itda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last      (out_ch.last)
);

// ----- tb/tb.sv -----
// Testbench for integer_to_decimal_ascii_top: drives numbers in every mode and
// checks each character beat against a predicted decimal text, with random idling.
// Depends on itda_pkg, itda_if and the RTL of the converter.
module tb import itda_pkg::*;;

  localparam mode_t MODE_SPARE6 = 3'd6;
  localparam mode_t MODE_SPARE7 = 3'd7;
  localparam int    STALL_LIMIT = 1000;
  localparam int    DRAIN_CYCLES = 48;
  localparam int    RANDOM_ITEMS = 256;

  // Predicts the text of each accepted number and matches character beats.
  class char_scoreboard;
    logic [CHAR_W:0] pending[$];   // {last, char_code}
    int unsigned     mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void add_char(logic [CHAR_W:0] beat);
      pending = {pending, beat};
    endfunction

    function void note_number(logic [63:0] raw, mode_t mode);
      logic [63:0] mask;
      logic [63:0] x;
      logic [63:0] mag;
      logic [3:0]  digs[DIGITS];
      int unsigned w;
      bit          sgn;
      bit          neg;
      int          n;
      case (mode)
        MODE_S16: begin w = 16; sgn = 1'b1; end
        MODE_U16: begin w = 16; sgn = 1'b0; end
        MODE_S32: begin w = 32; sgn = 1'b1; end
        MODE_U32: begin w = 32; sgn = 1'b0; end
        MODE_S64: begin w = 64; sgn = 1'b1; end
        default: begin w = 64; sgn = 1'b0; end
      endcase
      mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      x    = raw & mask;
      neg  = sgn && x[w-1];
      if (neg) begin
        mag = (~x + 64'd1) & mask;
        if (mag == 64'd0) mag = 64'd1 << (w - 1);
      end else begin
        mag = x;
      end
      n = 0;
      do begin
        digs[n] = 4'(mag % 64'd10);
        n++;
        mag = mag / 64'd10;
      end while (mag != 64'd0 && n < DIGITS);
      if (neg) add_char({1'b0, CHAR_MINUS});
      for (int i = n - 1; i >= 0; i--) begin
        add_char({i == 0, CHAR_W'(CHAR_ZERO + digs[i])});
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      logic [CHAR_W:0] want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: char 0x%02h last %0b", code, last);
        return;
      end
      want = pending.pop_front();
      if (want[CHAR_W-1:0] !== code || want[CHAR_W] !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                   want[CHAR_W-1:0], want[CHAR_W], code, last);
      end
    endfunction

    function int unsigned waiting();
      return pending.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;   // no idling on either side while set

  itda_in_if #(.VALUE_BITS(64)) in_ch();
  itda_out_if                   out_ch();

  char_scoreboard sb = new();

  integer_to_decimal_ascii_top #(.VALUE_BITS(64)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Present one number and hold it until the beat is taken.
  task automatic send_number(logic [63:0] value, mode_t mode);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.value_bits = value;
    in_ch.mode       = mode;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_number(value, mode);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    int unsigned k;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 99));
      1: begin
        // near a power of ten
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      2: begin
        // near a sign boundary, with junk above the width
        k = ($urandom_range(0, 2) == 0) ? 16 : (($urandom_range(0, 1) == 0) ? 32 : 64);
        v = {$urandom, $urandom};
        if (k < 64) v = (v >> k) << k;
        else v = '0;
        v = v | ((64'd1 << (k - 1)) + 64'($urandom_range(0, 2)) - 64'd1);
      end
      3: v = {$urandom, $urandom} | 64'h0000_0000_FFFF_0000 >> $urandom_range(0, 16);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  initial begin : stimulus
    rst_n            = 1'b0;
    steady           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = '0;
    in_ch.mode       = MODE_S16;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_number(64'd0, MODE_S16);
    send_number(64'd0, MODE_U64);
    send_number(64'hFFFF_FFFF_FFFF_0000, MODE_S16);
    send_number(64'h0000_0000_0000_7FFF, MODE_S16);
    send_number(64'h0000_0000_0000_8000, MODE_S16);
    send_number(64'h0000_0000_0000_FFFF, MODE_S16);
    send_number(64'h0000_0000_0000_FFFF, MODE_U16);
    send_number(64'hABCD_0000_0000_FFFF, MODE_U16);
    send_number(64'h0000_0000_7FFF_FFFF, MODE_S32);
    send_number(64'h0000_0000_8000_0000, MODE_S32);
    send_number(64'h1234_5678_FFFF_FFFF, MODE_S32);
    send_number(64'h0000_0000_FFFF_FFFF, MODE_U32);
    send_number(64'd9, MODE_U32);
    send_number(64'd10, MODE_S32);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_S64);
    send_number(64'h8000_0000_0000_0000, MODE_S64);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_S64);
    send_number(64'd1, MODE_S64);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_U64);
    send_number(64'd10000000000000000000, MODE_U64);
    send_number(64'd9999999999999999999, MODE_U64);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_SPARE6);
    send_number(64'h8000_0000_0000_0000, MODE_SPARE7);
    send_number(64'h5555_AAAA_5555_AAAA, MODE_SPARE7);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every third stretch of forty runs without idling
      if (i % 40 == 0) steady = ((i / 40) % 3 == 2);
      send_number(pick_value(), mode_t'($urandom_range(0, 7)));
    end
    steady      = 1'b0;
    in_ch.valid = 1'b0;

    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each beat.
  initial begin : sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_char(out_ch.char_code, out_ch.last);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
